// ===== design/ird_pkg.sv =====
// Shared types and constants for the input-restricted deque.
// No dependencies; imported by the deque top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package ird_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 6;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK = 2'd0,
        CMD_POP_FRONT = 2'd1,
        CMD_POP_BACK  = 2'd2,
        CMD_QUERY     = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== design/input_restricted_deque.sv =====
// Input-restricted deque: ring buffer of signed words, push at back, pop at either end.
// Depends on ird_pkg for depth, widths and the command and status codes.
// Push, query and refused commands give their result beat in the cycle after acceptance;
// a successful pop gives it after the synchronous slot memory read, via the read data
// register and then the result register. Throughput: 1 command per cycle for push and query
// while the result is not stalled; a pop holds off the next command until its data is back.
// Reset clears head, tail, occupancy and the result register; slot contents stay as they are.
`timescale 1ns / 1ps
`default_nettype none

module input_restricted_deque
    import ird_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cmd_valid,
    output logic                           cmd_ready,
    input  wire logic [CMD_W-1:0]          cmd,
    input  wire logic signed [DATA_W-1:0]  item,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output logic signed [DATA_W-1:0]       value,
    output logic [COUNT_W-1:0]             count,
    output logic [STAT_W-1:0]              status
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // Slot memory: one write port, one registered read port.
    logic [DATA_W-1:0] slots [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          occ_reg, occ_next;
    logic                      res_valid_reg, res_valid_next;
    logic signed [DATA_W-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    status_t                   status_reg, status_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [IDX_W-1:0]          head_inc;
    logic [IDX_W-1:0]          tail_inc;
    logic [IDX_W-1:0]          tail_dec;
    logic [COUNT_W+CNT_W-1:0]  count_ext;

    // Take a new beat only with no read in flight and the result register free or draining.
    assign cmd_ready = (state_reg == S_IDLE) && (!res_valid_reg || res_ready);
    assign accept    = cmd_valid && cmd_ready;

    assign full  = (occ_reg == CNT_W'(DEPTH));
    assign empty = (occ_reg == '0);

    // Wrap the ring indices in both directions.
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign tail_inc = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + IDX_W'(1);
    assign tail_dec = (tail_reg == '0) ? IDX_W'(DEPTH - 1) : tail_reg - IDX_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        res_valid_next = res_valid_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = tail_reg;
        mem_raddr      = head_reg;

        // Drop the held beat once the consumer takes it.
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (state_reg == S_READ)
        begin
            // Read data is back: present the popped word.
            value_next     = signed'(rd_data_reg);
            res_valid_next = 1'b1;
            state_next     = S_IDLE;
        end
        else if (accept)
        begin
            value_next  = '0;
            status_next = ST_OK;
            unique case (cmd_t'(cmd))
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                        count_next  = occ_reg;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = tail_reg;
                        tail_next  = tail_inc;
                        occ_next   = occ_reg + CNT_W'(1);
                        count_next = occ_reg + CNT_W'(1);
                    end
                    res_valid_next = 1'b1;
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next    = ST_EMPTY;
                        count_next     = '0;
                        res_valid_next = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = head_reg;
                        head_next  = head_inc;
                        occ_next   = occ_reg - CNT_W'(1);
                        count_next = occ_reg - CNT_W'(1);
                        state_next = S_READ;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next    = ST_EMPTY;
                        count_next     = '0;
                        res_valid_next = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = tail_dec;
                        tail_next  = tail_dec;
                        occ_next   = occ_reg - CNT_W'(1);
                        count_next = occ_reg - CNT_W'(1);
                        state_next = S_READ;
                    end
                end
                CMD_QUERY:
                begin
                    count_next     = occ_reg;
                    res_valid_next = 1'b1;
                end
            endcase
        end
    end

    // Slot memory. Writes and reads never target the same cycle, so no bypass is needed.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots[mem_waddr] <= item;
        end
        if (mem_re)
        begin
            rd_data_reg <= slots[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
            value_reg     <= '0;
            count_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            res_valid_reg <= res_valid_next;
            value_reg     <= value_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
        end
    end

    // Mask the occupancy to the width of the count field.
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    assign res_valid = res_valid_reg;
    assign value     = value_reg;
    assign count     = count_ext[COUNT_W-1:0];
    assign status    = status_reg;

endmodule

`default_nettype wire

// ===== design/ird_checker.sv =====
// Port-level assertions for the input-restricted deque, bound to its top level.
// Depends on ird_pkg for status codes and depth.
`timescale 1ns / 1ps
`default_nettype none

module ird_checker
    import ird_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      cmd_valid,
    input wire logic                      cmd_ready,
    input wire logic [CMD_W-1:0]          cmd,
    input wire logic signed [DATA_W-1:0]  item,
    input wire logic                      res_valid,
    input wire logic                      res_ready,
    input wire logic signed [DATA_W-1:0]  value,
    input wire logic [COUNT_W-1:0]        count,
    input wire logic [STAT_W-1:0]         status
);

    logic [COUNT_W+CNT_W-1:0] depth_ext;
    assign depth_ext = {{COUNT_W{1'b0}}, CNT_W'(DEPTH)};

    // Hold a waiting command beat until it is taken.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd) && $stable(item))
        else $error("command beat changed while waiting");

    // Hold a stalled result beat.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(value) && $stable(count)
            && $stable(status))
        else $error("result beat changed while stalled");

    // A stalled result blocks new commands.
    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("command taken while result stalled");

    // A refused push reports a full ring and no value.
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_FULL |-> value == '0 && count == depth_ext[COUNT_W-1:0])
        else $error("full status with wrong value or count");

    // A pop on an empty ring reports zero and no value.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_EMPTY |-> value == '0 && count == '0)
        else $error("empty status with wrong value or count");

endmodule

bind input_restricted_deque ird_checker u_ird_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .value     (value),
    .count     (count),
    .status    (status)
);

`default_nettype wire
